/* sv/rmrc_pkg.sv */
// Shared types, constants and counter slot mapping for the relay matrix route controller.
package rmrc_pkg;

   localparam int ROWS    = 4;
   localparam int COLUMNS = 6;
   localparam int NBITS   = ROWS * COLUMNS;
   localparam int NCOUNT  = NBITS + 1;
   localparam int BIT_W   = $clog2(NBITS);
   localparam int ADDR_W  = $clog2(NCOUNT);
   localparam int SWEEP_W = $clog2(NCOUNT + 1);

   localparam logic [6:0] POWER_CHANNEL   = 7'd3;
   localparam logic [7:0] CRC_LIMIT_RESET = 8'd10;
   localparam logic [7:0] CRC_ERRORS_MAX  = 8'hFF;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ILLEGAL   = 3'd1;
   localparam logic [2:0] ST_NO_SYNC   = 3'd2;
   localparam logic [2:0] ST_CRC       = 3'd3;
   localparam logic [2:0] ST_XFER      = 3'd4;
   localparam logic [2:0] ST_LINK_LOST = 3'd5;

   localparam logic [1:0] XFER_OK  = 2'd0;
   localparam logic [1:0] XFER_CRC = 2'd1;

   typedef enum logic [2:0] {
      OP_OPEN   = 3'd0,
      OP_CLOSE  = 3'd1,
      OP_QUERY  = 3'd2,
      OP_CYCLES = 3'd3,
      OP_TOGGLE = 3'd4,
      OP_CLEAR  = 3'd5,
      OP_TICK   = 3'd6,
      OP_SYNC   = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0] op;
      logic [6:0] channel;
      logic       list_last;
      logic [1:0] xfer_status;
      logic       sync_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [31:0]      value;
      logic [NBITS-1:0] routes_now;
      logic             relay_now;
   } rsp_type;

   // decoded word held in the queue between front and back
   typedef struct packed {
      op_type           op;
      logic             illegal;
      logic             power;
      logic [BIT_W-1:0] bit_idx;
      logic             list_last;
      logic [1:0]       xfer_status;
      logic             sync_ok;
   } item_type;

   // counter slot: power relay at 0, signal relays after it
   function automatic logic [ADDR_W-1:0] count_addr(input item_type it);
      logic [ADDR_W-1:0] a;
      begin
         a = ADDR_W'(it.bit_idx) + ADDR_W'(1);
         if (it.power || it.illegal) begin
            count_addr = '0;
         end else begin
            count_addr = a;
         end
      end
   endfunction

endpackage

/* sv/rmrc_front.sv */
// Front end: decodes channel numbers and queues decoded words for the back end.
module rmrc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rmrc_pkg::req_type req_word,
   output logic              q_valid,
   output rmrc_pkg::item_type q_item,
   input  logic              q_pop
);

   localparam int DEPTH = 2;

   rmrc_pkg::item_type fifo_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   rmrc_pkg::item_type dec;

   logic [14:0] prod;
   logic [3:0]  row;
   logic [6:0]  col;
   logic [6:0]  row_x10;
   logic [7:0]  lin;
   logic        in_range;

   // divide by ten through a reciprocal multiply, exact for 7-bit inputs
   always_comb begin
      prod     = 15'(req_word.channel) * 15'd205;
      row      = prod[14:11];
      row_x10  = 7'(row) * 7'd10;
      col      = req_word.channel - row_x10;
      in_range = (row >= 4'd1) && (row <= 4'(rmrc_pkg::ROWS))
               && (col >= 7'd1) && (col <= 7'(rmrc_pkg::COLUMNS));
      lin      = 8'(row - 4'd1) * 8'(rmrc_pkg::COLUMNS) + 8'(col - 7'd1);

      dec.op          = rmrc_pkg::op_type'(req_word.op);
      dec.power       = (req_word.channel == rmrc_pkg::POWER_CHANNEL);
      dec.illegal     = !dec.power && !in_range;
      dec.bit_idx     = (dec.power || !in_range) ? '0 : lin[rmrc_pkg::BIT_W-1:0];
      dec.list_last   = req_word.list_last;
      dec.xfer_status = req_word.xfer_status;
      dec.sync_ok     = req_word.sync_ok;
   end

   assign req_stall = (count_ff == 2'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

/* sv/rmrc_back.sv */
// Back end: executes route operations, link bookkeeping and cycle counter updates.
module rmrc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  rmrc_pkg::item_type q_item,
   output logic               q_pop,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rmrc_pkg::rsp_type  rsp_word
);

   localparam int NB = rmrc_pkg::NBITS;
   localparam int NC = rmrc_pkg::NCOUNT;
   localparam int AW = rmrc_pkg::ADDR_W;
   localparam int SW = rmrc_pkg::SWEEP_W;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_SWEEP = 3'b100
   } state_type;

   state_type          st_ff, st_in;
   rmrc_pkg::item_type cur_ff, cur_in;
   logic [7:0]     limit_ff;
   logic [NB-1:0]  route_ff, route_in;
   logic           relay_ff, relay_in;
   logic [NB-1:0]  staged_ff, staged_in;
   logic           staged_relay_ff, staged_relay_in;
   logic           busy_ff, busy_in;
   logic           bad_ff, bad_in;
   logic [NB-1:0]  sent_ff, sent_in;
   logic           sent_relay_ff, sent_relay_in;
   logic           link_ff, link_in;
   logic [7:0]     crc_ff, crc_in;
   logic [NC-1:0]  rising_ff, rising_in;
   logic [SW-1:0]  sweep_ff, sweep_in;
   logic           out_valid_ff, out_valid_in;
   rmrc_pkg::rsp_type out_ff, out_in;

   logic [31:0]    mem [NC];
   logic [NC-1:0]  cnt_vld_ff;
   logic [31:0]    rd_data_ff;
   logic           rd_vld_ff;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [31:0]    wr_data;

   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   always_comb begin
      logic [2:0]    status;
      logic [31:0]   value;
      logic [NB-1:0] stg;
      logic          stg_relay;
      logic          bad;
      logic [NB-1:0] onehot;
      logic [7:0]    crc_next;
      logic [SW-1:0] prev;

      status    = rmrc_pkg::ST_OK;
      value     = '0;
      onehot    = NB'(1) << cur_ff.bit_idx;
      stg       = busy_ff ? staged_ff : route_ff;
      stg_relay = busy_ff ? staged_relay_ff : relay_ff;
      bad       = busy_ff ? bad_ff : 1'b0;
      crc_next  = (crc_ff < rmrc_pkg::CRC_ERRORS_MAX) ? crc_ff + 8'd1 : crc_ff;
      prev      = sweep_ff - SW'(1);

      st_in           = st_ff;
      cur_in          = cur_ff;
      route_in        = route_ff;
      relay_in        = relay_ff;
      staged_in       = staged_ff;
      staged_relay_in = staged_relay_ff;
      busy_in         = busy_ff;
      bad_in          = bad_ff;
      sent_in         = sent_ff;
      sent_relay_in   = sent_relay_ff;
      link_in         = link_ff;
      crc_in          = crc_ff;
      rising_in       = rising_ff;
      sweep_in        = sweep_ff;
      out_valid_in    = out_valid_ff && rsp_stall;
      out_in          = out_ff;
      q_pop           = 1'b0;
      rd_addr         = rmrc_pkg::count_addr(q_item);
      wr_en           = 1'b0;
      wr_addr         = prev[AW-1:0];
      wr_data         = (rd_vld_ff ? rd_data_ff : 32'd0) + 32'd1;

      unique case (st_ff)
         S_IDLE: begin
            if (q_valid && (!out_valid_ff || !rsp_stall)) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               st_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            st_in = S_IDLE;
            unique case (cur_ff.op) inside
               rmrc_pkg::OP_OPEN, rmrc_pkg::OP_CLOSE: begin
                  if (!bad) begin
                     if (cur_ff.illegal) begin
                        bad = 1'b1;
                     end else if (cur_ff.power) begin
                        stg_relay = (cur_ff.op == rmrc_pkg::OP_OPEN);
                     end else if (cur_ff.op == rmrc_pkg::OP_OPEN) begin
                        stg = stg | onehot;
                     end else begin
                        stg = stg & ~onehot;
                     end
                  end
                  status          = bad ? rmrc_pkg::ST_ILLEGAL : rmrc_pkg::ST_OK;
                  staged_in       = stg;
                  staged_relay_in = stg_relay;
                  bad_in          = bad;
                  busy_in         = !cur_ff.list_last;
                  if (cur_ff.list_last && !bad) begin
                     route_in = stg;
                     relay_in = stg_relay;
                  end
               end
               rmrc_pkg::OP_QUERY: begin
                  if (cur_ff.illegal) begin
                     status = rmrc_pkg::ST_ILLEGAL;
                  end else if (cur_ff.power) begin
                     value = 32'(relay_ff);
                  end else begin
                     value = 32'(|(route_ff & onehot));
                  end
               end
               rmrc_pkg::OP_CYCLES: begin
                  if (cur_ff.illegal) begin
                     status = rmrc_pkg::ST_ILLEGAL;
                  end else begin
                     value = rd_vld_ff ? rd_data_ff : 32'd0;
                  end
               end
               rmrc_pkg::OP_TOGGLE: begin
                  if (cur_ff.illegal) begin
                     status = rmrc_pkg::ST_ILLEGAL;
                  end else if (cur_ff.power) begin
                     relay_in = !relay_ff;
                  end else begin
                     route_in = route_ff ^ onehot;
                  end
               end
               rmrc_pkg::OP_CLEAR: begin
                  route_in = '0;
               end
               rmrc_pkg::OP_TICK: begin
                  if (!link_ff) begin
                     status = rmrc_pkg::ST_NO_SYNC;
                  end else if ((route_ff != sent_ff) || (relay_ff != sent_relay_ff)) begin
                     sent_in       = route_ff;
                     sent_relay_in = relay_ff;
                     if (cur_ff.xfer_status == rmrc_pkg::XFER_OK) begin
                        crc_in    = 8'd0;
                        rising_in = {~sent_ff & route_ff, !sent_relay_ff && relay_ff};
                        sweep_in  = '0;
                        st_in     = S_SWEEP;
                     end else if (cur_ff.xfer_status == rmrc_pkg::XFER_CRC) begin
                        crc_in = crc_next;
                        if (crc_next >= limit_ff) begin
                           link_in = 1'b0;
                           status  = rmrc_pkg::ST_LINK_LOST;
                        end else begin
                           status = rmrc_pkg::ST_CRC;
                        end
                     end else begin
                        status = rmrc_pkg::ST_XFER;
                     end
                  end
               end
               rmrc_pkg::OP_SYNC: begin
                  if (!link_ff) begin
                     if (cur_ff.sync_ok) begin
                        link_in = 1'b1;
                        crc_in  = 8'd0;
                     end else begin
                        status = rmrc_pkg::ST_NO_SYNC;
                     end
                  end
               end
               default: begin
                  status = rmrc_pkg::ST_OK;
               end
            endcase
            out_valid_in      = 1'b1;
            out_in.status     = status;
            out_in.value      = value;
            out_in.routes_now = route_in;
            out_in.relay_now  = relay_in;
         end
         S_SWEEP: begin
            // read slot n while slot n-1 is written back
            rd_addr  = (sweep_ff < SW'(NC)) ? sweep_ff[AW-1:0] : '0;
            wr_en    = (sweep_ff != '0) && rising_ff[prev[AW-1:0]];
            sweep_in = sweep_ff + SW'(1);
            if (sweep_ff == SW'(NC)) begin
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= S_IDLE;
         limit_ff        <= rmrc_pkg::CRC_LIMIT_RESET;
         route_ff        <= '0;
         relay_ff        <= 1'b0;
         staged_ff       <= '0;
         staged_relay_ff <= 1'b0;
         busy_ff         <= 1'b0;
         bad_ff          <= 1'b0;
         sent_ff         <= '1;
         sent_relay_ff   <= 1'b0;
         link_ff         <= 1'b0;
         crc_ff          <= 8'd0;
         sweep_ff        <= '0;
         out_valid_ff    <= 1'b0;
         cnt_vld_ff      <= '0;
      end else begin
         st_ff           <= st_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         route_ff        <= route_in;
         relay_ff        <= relay_in;
         staged_ff       <= staged_in;
         staged_relay_ff <= staged_relay_in;
         busy_ff         <= busy_in;
         bad_ff          <= bad_in;
         sent_ff         <= sent_in;
         sent_relay_ff   <= sent_relay_in;
         link_ff         <= link_in;
         crc_ff          <= crc_in;
         sweep_ff        <= sweep_in;
         out_valid_ff    <= out_valid_in;
         if (wr_en) begin
            cnt_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      rising_ff <= rising_in;
      out_ff    <= out_in;
   end

   // cycle counter memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= cnt_vld_ff[rd_addr];
   end

endmodule

/* sv/relay_matrix_route_controller_top.sv */
// Top level of the relay matrix route controller.
// Drives a 4x6 signal relay matrix plus one power relay, addressed by decimal
// channel numbers (row*10+column, channel 3 is the power relay). A front end
// decodes each request word into a two-entry queue; a back end executes one
// word at a time and holds the response in an output register, so requests
// can still enter the queue while a response waits. A transfer tick that
// succeeds with changed routes then walks all 25 relay cycle counters
// through a counter memory with one read and one write port, one counter
// per cycle, in a sweep state before the next word starts.
// The counters read as zero after reset; there is no clearing pass.
module relay_matrix_route_controller_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rmrc_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmrc_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   logic               q_valid;
   rmrc_pkg::item_type q_item;
   logic               q_pop;

   rmrc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   rmrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.status <= rmrc_pkg::ST_LINK_LOST))
      else $error("response status out of range");

   a_fail_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status != rmrc_pkg::ST_OK)) |-> (rsp_word.value == 32'd0))
      else $error("failed request returned nonzero value");

   a_no_pop_while_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !q_pop)
      else $error("word taken while response register is held");

endmodule

/* tb/tb_relay_matrix_route_controller_top.sv */
// Testbench for the relay matrix route controller: directed table, random route traffic, scoreboard.
`timescale 1ns / 100ps

module tb_relay_matrix_route_controller_top;
   import rmrc_pkg::*;

   localparam logic [1:0] XFER_OTHER = 2'd2;
   localparam logic [1:0] XFER_SPARE = 2'd3;
   localparam logic       FIXED      = 1'b1;
   localparam logic       PREDICT    = 1'b0;
   localparam int         SETTLE     = 40;
   localparam int         WATCHDOG   = 2000;
   localparam int         PHASES     = 5;
   localparam int         PHASE_WORDS = 130;

   typedef struct packed {
      req_type    word;
      logic       fixed;
      rsp_type    want;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;
   logic    csr_valid;
   logic    csr_ready;
   logic [7:0] csr_data;

   // expectation attached to the word on the request port
   logic    want_fixed;
   rsp_type want_rsp;
   bit      calm;

   // route model state
   logic [NBITS-1:0] live_routes;
   logic             live_power;
   logic [NBITS-1:0] stage_routes;
   logic             stage_power;
   logic             in_list;
   logic             list_failed;
   logic [NBITS-1:0] last_sent_routes;
   logic             last_sent_power;
   logic             link_ok;
   logic [7:0]       crc_run;
   logic [7:0]       crc_limit;
   logic [31:0]      cycle_count [NCOUNT];

   rsp_type expected_rsp_q [$];
   int      check_errors;
   int      quiet_cycles;

   dir_row_type dir_table [26] = '{
      '{'{OP_QUERY,  7'd11,  1'b0, XFER_OK,    1'b0}, FIXED, '{ST_OK, 32'd0, 24'd0, 1'b0}},
      '{'{OP_CYCLES, 7'd3,   1'b0, XFER_OK,    1'b0}, FIXED, '{ST_OK, 32'd0, 24'd0, 1'b0}},
      '{'{OP_TICK,   7'd0,   1'b0, XFER_OK,    1'b0}, FIXED,
        '{ST_NO_SYNC, 32'd0, 24'd0, 1'b0}},
      '{'{OP_SYNC,   7'd0,   1'b0, XFER_OK,    1'b0}, FIXED,
        '{ST_NO_SYNC, 32'd0, 24'd0, 1'b0}},
      '{'{OP_QUERY,  7'd1,   1'b0, XFER_OK,    1'b0}, FIXED,
        '{ST_ILLEGAL, 32'd0, 24'd0, 1'b0}},
      '{'{OP_TOGGLE, 7'd127, 1'b1, XFER_SPARE, 1'b1}, FIXED,
        '{ST_ILLEGAL, 32'd0, 24'd0, 1'b0}},
      '{'{OP_CYCLES, 7'd50,  1'b0, XFER_OK,    1'b0}, FIXED,
        '{ST_ILLEGAL, 32'd0, 24'd0, 1'b0}},
      '{'{OP_QUERY,  7'd47,  1'b0, XFER_OK,    1'b0}, FIXED,
        '{ST_ILLEGAL, 32'd0, 24'd0, 1'b0}},
      '{'{OP_SYNC,   7'd0,   1'b0, XFER_OK,    1'b1}, FIXED, '{ST_OK, 32'd0, 24'd0, 1'b0}},
      '{'{OP_SYNC,   7'd0,   1'b0, XFER_OK,    1'b0}, FIXED, '{ST_OK, 32'd0, 24'd0, 1'b0}},
      '{'{OP_TICK,   7'd0,   1'b0, XFER_OK,    1'b0}, FIXED, '{ST_OK, 32'd0, 24'd0, 1'b0}},
      '{'{OP_TICK,   7'd0,   1'b0, XFER_OK,    1'b0}, FIXED, '{ST_OK, 32'd0, 24'd0, 1'b0}},
      '{'{OP_OPEN,   7'd11,  1'b0, XFER_OK,    1'b0}, PREDICT, '0},
      '{'{OP_OPEN,   7'd46,  1'b0, XFER_OK,    1'b0}, PREDICT, '0},
      '{'{OP_OPEN,   7'd3,   1'b1, XFER_OK,    1'b0}, PREDICT, '0},
      '{'{OP_TICK,   7'd0,   1'b0, XFER_OK,    1'b0}, PREDICT, '0},
      '{'{OP_CYCLES, 7'd46,  1'b0, XFER_OK,    1'b0}, PREDICT, '0},
      '{'{OP_CLOSE,  7'd11,  1'b0, XFER_OK,    1'b0}, PREDICT, '0},
      '{'{OP_OPEN,   7'd17,  1'b0, XFER_OK,    1'b0}, PREDICT, '0},
      '{'{OP_OPEN,   7'd12,  1'b1, XFER_OK,    1'b0}, PREDICT, '0},
      '{'{OP_TOGGLE, 7'd3,   1'b0, XFER_OK,    1'b0}, PREDICT, '0},
      '{'{OP_TICK,   7'd0,   1'b0, XFER_CRC,   1'b0}, PREDICT, '0},
      '{'{OP_CLEAR,  7'd0,   1'b0, XFER_OK,    1'b0}, PREDICT, '0},
      '{'{OP_TICK,   7'd0,   1'b0, XFER_OTHER, 1'b0}, PREDICT, '0},
      '{'{OP_TOGGLE, 7'd11,  1'b0, XFER_OK,    1'b0}, PREDICT, '0},
      '{'{OP_TICK,   7'd0,   1'b0, XFER_SPARE, 1'b0}, PREDICT, '0}
   };

   relay_matrix_route_controller_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // bit index of a signal relay, NBITS for the power relay, -1 if illegal
   function automatic int relay_index(input logic [6:0] ch);
      int col;
      int row;
      if (ch == POWER_CHANNEL) return NBITS;
      col = int'(ch) % 10;
      row = int'(ch) / 10;
      if (col < 1 || col > COLUMNS || row < 1 || row > ROWS) return -1;
      return (row - 1) * COLUMNS + col - 1;
   endfunction

   function automatic rsp_type route_step(input req_type w);
      rsp_type          r;
      int               idx;
      logic [NBITS-1:0] rising;
      logic             rise_power;
      r = '0;
      idx = relay_index(w.channel);
      case (op_type'(w.op))
         OP_OPEN, OP_CLOSE: begin
            if (!in_list) begin
               stage_routes = live_routes;
               stage_power = live_power;
               list_failed = 1'b0;
               in_list = 1'b1;
            end
            if (!list_failed) begin
               if (idx < 0) begin
                  list_failed = 1'b1;
               end else if (idx == NBITS) begin
                  stage_power = (w.op == OP_OPEN);
               end else begin
                  stage_routes[idx] = (w.op == OP_OPEN);
               end
            end
            r.status = list_failed ? ST_ILLEGAL : ST_OK;
            if (w.list_last) begin
               if (!list_failed) begin
                  live_routes = stage_routes;
                  live_power = stage_power;
               end
               in_list = 1'b0;
            end
         end
         OP_QUERY: begin
            if (idx < 0) r.status = ST_ILLEGAL;
            else if (idx == NBITS) r.value = {31'd0, live_power};
            else r.value = {31'd0, live_routes[idx]};
         end
         OP_CYCLES: begin
            if (idx < 0) r.status = ST_ILLEGAL;
            else if (idx == NBITS) r.value = cycle_count[0];
            else r.value = cycle_count[idx + 1];
         end
         OP_TOGGLE: begin
            if (idx < 0) r.status = ST_ILLEGAL;
            else if (idx == NBITS) live_power = ~live_power;
            else live_routes[idx] = ~live_routes[idx];
         end
         OP_CLEAR: live_routes = '0;
         OP_TICK: begin
            if (!link_ok) begin
               r.status = ST_NO_SYNC;
            end else if (live_routes != last_sent_routes || live_power != last_sent_power) begin
               rising = ~last_sent_routes & live_routes;
               rise_power = ~last_sent_power & live_power;
               last_sent_routes = live_routes;
               last_sent_power = live_power;
               if (w.xfer_status == XFER_OK) begin
                  crc_run = '0;
                  for (int i = 0; i < NBITS; i++) begin
                     if (rising[i]) cycle_count[i + 1] = cycle_count[i + 1] + 32'd1;
                  end
                  if (rise_power) cycle_count[0] = cycle_count[0] + 32'd1;
               end else if (w.xfer_status == XFER_CRC) begin
                  if (crc_run != CRC_ERRORS_MAX) crc_run = crc_run + 8'd1;
                  if (crc_run >= crc_limit) begin
                     link_ok = 1'b0;
                     r.status = ST_LINK_LOST;
                  end else begin
                     r.status = ST_CRC;
                  end
               end else begin
                  r.status = ST_XFER;
               end
            end
         end
         OP_SYNC: begin
            if (!link_ok) begin
               if (w.sync_ok) begin
                  link_ok = 1'b1;
                  crc_run = '0;
               end else begin
                  r.status = ST_NO_SYNC;
               end
            end
         end
         default: ;
      endcase
      r.routes_now = live_routes;
      r.relay_now = live_power;
      return r;
   endfunction

   function automatic logic [6:0] pick_channel(input int bad_pct);
      if ($urandom_range(0, 99) < bad_pct) return 7'($urandom_range(0, 127));
      if ($urandom_range(0, 15) == 0) return POWER_CHANNEL;
      return 7'($urandom_range(1, ROWS) * 10 + $urandom_range(1, COLUMNS));
   endfunction

   task automatic send_word(input req_type w, input logic fixed, input rsp_type want);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      want_fixed <= fixed;
      want_rsp <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off until every response is back and any counter walk is done
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_crc_limit(input logic [7:0] lim);
      csr_valid <= 1'b1;
      csr_data <= lim;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      crc_limit = lim;
   endtask

   task automatic run_random(input int count, input int crc_pct);
      int      n;
      int      pick;
      int      len;
      int      roll;
      req_type w;
      n = 0;
      while (n < count) begin
         if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         w.channel = pick_channel(10);
         w.list_last = 1'($urandom_range(0, 1));
         w.xfer_status = 2'($urandom_range(0, 3));
         w.sync_ok = 1'($urandom_range(0, 1));
         if (pick < 40) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
               w.op = $urandom_range(0, 1) ? OP_OPEN : OP_CLOSE;
               w.channel = pick_channel(8);
               // now and then a list runs on without its end mark
               w.list_last = (k == len - 1) && ($urandom_range(0, 9) != 0);
               w.xfer_status = 2'($urandom_range(0, 3));
               w.sync_ok = 1'($urandom_range(0, 1));
               send_word(w, PREDICT, '0);
               n++;
            end
         end else begin
            if (pick < 52) begin
               w.op = OP_TOGGLE;
            end else if (pick < 62) begin
               w.op = OP_QUERY;
            end else if (pick < 72) begin
               w.op = OP_CYCLES;
            end else if (pick < 75) begin
               w.op = OP_CLEAR;
            end else if (pick < 92) begin
               w.op = OP_TICK;
               roll = $urandom_range(0, 99);
               if (roll < crc_pct) w.xfer_status = XFER_CRC;
               else if (roll < crc_pct + 10) w.xfer_status = roll[0] ? XFER_OTHER : XFER_SPARE;
               else w.xfer_status = XFER_OK;
            end else begin
               w.op = OP_SYNC;
               w.sync_ok = ($urandom_range(0, 4) != 0);
            end
            send_word(w, PREDICT, '0);
            n++;
         end
      end
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type predicted;
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = route_step(req_word);
            expected_rsp_q.push_back(want_fixed ? want_rsp : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response word: status %0d value %0h", rsp_word.status,
                      rsp_word.value);
               check_errors++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_word.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_word.status);
                  check_errors++;
               end
               if (rsp_word.value !== want.value) begin
                  $error("value: expected %0h, got %0h", want.value, rsp_word.value);
                  check_errors++;
               end
               if (rsp_word.routes_now !== want.routes_now) begin
                  $error("routes_now: expected %06h, got %06h", want.routes_now,
                         rsp_word.routes_now);
                  check_errors++;
               end
               if (rsp_word.relay_now !== want.relay_now) begin
                  $error("relay_now: expected %0d, got %0d", want.relay_now,
                         rsp_word.relay_now);
                  check_errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : rsp_side
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 10);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin : stimulus
      logic [7:0] phase_limit [PHASES];
      int         phase_crc [PHASES];
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      want_fixed = 1'b0;
      want_rsp = '0;
      calm = 1'b0;
      check_errors = 0;
      quiet_cycles = 0;
      live_routes = '0;
      live_power = 1'b0;
      stage_routes = '0;
      stage_power = 1'b0;
      in_list = 1'b0;
      list_failed = 1'b0;
      last_sent_routes = '1;
      last_sent_power = 1'b0;
      link_ok = 1'b0;
      crc_run = '0;
      crc_limit = CRC_LIMIT_RESET;
      for (int i = 0; i < NCOUNT; i++) cycle_count[i] = '0;
      phase_limit = '{8'd1, 8'd255, 8'd3, 8'($urandom_range(1, 255)), 8'd2};
      phase_crc = '{30, 40, 60, 40, 50};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) send_word(dir_table[i].word, dir_table[i].fixed, dir_table[i].want);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_crc_limit(phase_limit[p]);
         run_random(PHASE_WORDS, phase_crc[p]);
      end

      drain();
      if (check_errors == 0 && expected_rsp_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
sv/rmrc_pkg.sv
sv/rmrc_front.sv
sv/rmrc_back.sv
sv/relay_matrix_route_controller_top.sv
tb/tb_relay_matrix_route_controller_top.sv
